/* rtl/urc_pkg.sv */
`default_nettype none

package urc_pkg;

  // Width of the echo tick counter; the count saturates at all ones.
  localparam int unsigned COUNT_WIDTH = 24;

  localparam int unsigned DIST_WIDTH  = 19;
  localparam int unsigned DIGIT_WIDTH = 4;
  localparam int unsigned TICK_WIDTH  = 20;
  localparam int unsigned REM_WIDTH   = 15;
  localparam int unsigned CFG_WIDTH   = 20;
  localparam int unsigned CFG_IDX_WIDTH = 2;

  localparam int unsigned TRIG_WIDTH   = 8;
  localparam int unsigned THRESH_WIDTH = 10;

  // Distance is count * 343 / 20000, kept as a running quotient and remainder.
  localparam logic [REM_WIDTH-1:0]  SOUND_STEP  = REM_WIDTH'(343);
  localparam logic [REM_WIDTH-1:0]  SOUND_DIV   = REM_WIDTH'(20000);
  localparam logic [DIST_WIDTH-1:0] DIST_MAX    = '1;
  localparam logic [DIGIT_WIDTH-1:0] DIGIT_NINE = DIGIT_WIDTH'(9);

  // Configuration register indexes.
  localparam logic [CFG_IDX_WIDTH-1:0] REG_TRIG_LOW  = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_TRIG_HIGH = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_NEAR_THR  = 2'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_BLINK     = 2'd3;

  // Configuration reset values.
  localparam logic [TRIG_WIDTH-1:0]   TRIG_LOW_RST  = TRIG_WIDTH'(2);
  localparam logic [TRIG_WIDTH-1:0]   TRIG_HIGH_RST = TRIG_WIDTH'(10);
  localparam logic [THRESH_WIDTH-1:0] NEAR_THR_RST  = THRESH_WIDTH'(5);
  localparam logic [TICK_WIDTH-1:0]   BLINK_RST     = TICK_WIDTH'(100000);

  typedef enum logic [2:0] {
    PH_TRIG_LOW  = 3'd0,
    PH_TRIG_HIGH = 3'd1,
    PH_WAIT_RISE = 3'd2,
    PH_COUNT     = 3'd3,
    PH_LED_ON    = 3'd4,
    PH_LED_OFF   = 3'd5
  } phase_t;

  typedef struct packed {
    logic                   trigger_out;
    logic                   led_out;
    logic                   result_valid;
    logic [DIST_WIDTH-1:0]  distance_cm;
    logic [DIGIT_WIDTH-1:0] digit_hundreds;
    logic [DIGIT_WIDTH-1:0] digit_tens;
    logic [DIGIT_WIDTH-1:0] digit_ones;
    logic                   near_flag;
  } result_t;

endpackage

`default_nettype wire

/* rtl/urc_in_if.sv */
`default_nettype none

interface urc_in_if;
  logic valid;
  logic ready;
  logic echo_level;

  modport source (output valid, output echo_level, input ready);
  modport sink   (input valid, input echo_level, output ready);
endinterface

`default_nettype wire

/* rtl/urc_out_if.sv */
`default_nettype none

interface urc_out_if;
  import urc_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   trigger_out;
  logic                   led_out;
  logic                   result_valid;
  logic [DIST_WIDTH-1:0]  distance_cm;
  logic [DIGIT_WIDTH-1:0] digit_hundreds;
  logic [DIGIT_WIDTH-1:0] digit_tens;
  logic [DIGIT_WIDTH-1:0] digit_ones;
  logic                   near_flag;

  modport source (
    output valid, output trigger_out, output led_out, output result_valid,
    output distance_cm, output digit_hundreds, output digit_tens,
    output digit_ones, output near_flag, input ready
  );
  modport sink (
    input valid, input trigger_out, input led_out, input result_valid,
    input distance_cm, input digit_hundreds, input digit_tens,
    input digit_ones, input near_flag, output ready
  );
endinterface

`default_nettype wire

/* rtl/ultrasonic_range_controller.sv */
`default_nettype none

// Channel   Direction  Beat contents
// in_chan   sink       echo_level: sampled echo pin level for one 1 us tick
// out_chan  source     trigger_out, led_out, result_valid, distance_cm,
//                      digit_hundreds, digit_tens, digit_ones, near_flag
// cfg_*     write      cfg_index selects the register, cfg_data carries it
//
// Every input beat produces exactly one output beat. A new input beat can be
// taken every cycle while in_chan.ready is high; the rate is set by the
// single state update between the input handshake and the result register.
// Reset (rst_n low at a clock edge) returns the ranging cycle to the trigger
// low phase and the configuration registers to their defaults. When the sink
// stalls, one extra result is held in a skid register and in_chan.ready drops
// only once both the result register and the skid register are full.

module ultrasonic_range_controller (
  input  wire                              clk,
  input  wire                              rst_n,
  urc_in_if.sink                           in_chan,
  urc_out_if.source                        out_chan,
  input  wire                              cfg_wr_en,
  input  wire [urc_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
  input  wire [urc_pkg::CFG_WIDTH-1:0]     cfg_data
);
  import urc_pkg::*;

  // Configuration registers.
  logic [TRIG_WIDTH-1:0]   trig_low_r;
  logic [TRIG_WIDTH-1:0]   trig_high_r;
  logic [THRESH_WIDTH-1:0] near_thr_r;
  logic [TICK_WIDTH-1:0]   blink_r;

  // Ranging state. Besides the raw echo count, the distance is kept as a
  // running quotient and remainder of count * 343 / 20000, and its value
  // modulo 1000 as three decimal digits, so the report needs no divider.
  phase_t                 phase_r,  phase_nxt;
  logic [TICK_WIDTH-1:0]  ticks_r,  ticks_nxt;
  logic [COUNT_WIDTH-1:0] count_r,  count_nxt;
  logic [REM_WIDTH-1:0]   rem_r,    rem_nxt;
  logic [DIST_WIDTH-1:0]  dist_r,   dist_nxt;
  logic [DIGIT_WIDTH-1:0] d100_r,   d100_nxt;
  logic [DIGIT_WIDTH-1:0] d10_r,    d10_nxt;
  logic [DIGIT_WIDTH-1:0] d1_r,     d1_nxt;

  // Result register and skid register.
  result_t main_r, skid_r, res_nxt;
  logic    main_v_r, skid_v_r;

  logic                  push, pop, main_free;
  logic [TICK_WIDTH-1:0] ticks_inc;
  logic [REM_WIDTH-1:0]  rem_sum;
  logic                  rem_wrap;
  logic                  near;

  assign ticks_inc = ticks_r + 1'b1;
  assign rem_sum   = rem_r + SOUND_STEP;
  assign rem_wrap  = (rem_sum >= SOUND_DIV);
  assign near      = (dist_r <= DIST_WIDTH'(near_thr_r));

  assign in_chan.ready = !skid_v_r;
  assign push          = in_chan.valid && !skid_v_r;
  assign pop           = main_v_r && out_chan.ready;
  assign main_free     = !main_v_r || pop;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_low_r  <= TRIG_LOW_RST;
      trig_high_r <= TRIG_HIGH_RST;
      near_thr_r  <= NEAR_THR_RST;
      blink_r     <= BLINK_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_TRIG_LOW:  trig_low_r  <= cfg_data[TRIG_WIDTH-1:0];
        REG_TRIG_HIGH: trig_high_r <= cfg_data[TRIG_WIDTH-1:0];
        REG_NEAR_THR:  near_thr_r  <= cfg_data[THRESH_WIDTH-1:0];
        REG_BLINK:     blink_r     <= cfg_data[TICK_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Next state. A timed phase ends on the tick where the incremented tick
  // count reaches its register; a register of zero therefore acts as one.
  always_comb begin
    phase_nxt = phase_r;
    ticks_nxt = ticks_r;
    count_nxt = count_r;
    rem_nxt   = rem_r;
    dist_nxt  = dist_r;
    d100_nxt  = d100_r;
    d10_nxt   = d10_r;
    d1_nxt    = d1_r;
    unique case (phase_r)
      PH_TRIG_LOW: begin
        if (ticks_inc >= TICK_WIDTH'(trig_low_r)) begin
          ticks_nxt = '0;
          phase_nxt = PH_TRIG_HIGH;
        end else begin
          ticks_nxt = ticks_inc;
        end
      end
      PH_TRIG_HIGH: begin
        if (ticks_inc >= TICK_WIDTH'(trig_high_r)) begin
          ticks_nxt = '0;
          phase_nxt = PH_WAIT_RISE;
        end else begin
          ticks_nxt = ticks_inc;
        end
      end
      PH_WAIT_RISE: begin
        // The rising tick counts as the first echo tick.
        if (in_chan.echo_level) begin
          count_nxt = COUNT_WIDTH'(1);
          rem_nxt   = SOUND_STEP;
          dist_nxt  = '0;
          d100_nxt  = '0;
          d10_nxt   = '0;
          d1_nxt    = '0;
          phase_nxt = PH_COUNT;
        end
      end
      PH_COUNT: begin
        if (in_chan.echo_level) begin
          if (count_r != '1) begin
            count_nxt = count_r + 1'b1;
            rem_nxt   = rem_wrap ? rem_sum - SOUND_DIV : rem_sum;
            // The distance saturates; its digits freeze along with it.
            if (rem_wrap && dist_r != DIST_MAX) begin
              dist_nxt = dist_r + 1'b1;
              if (d1_r == DIGIT_NINE) begin
                d1_nxt = '0;
                if (d10_r == DIGIT_NINE) begin
                  d10_nxt  = '0;
                  d100_nxt = (d100_r == DIGIT_NINE) ? '0 : d100_r + 1'b1;
                end else begin
                  d10_nxt = d10_r + 1'b1;
                end
              end else begin
                d1_nxt = d1_r + 1'b1;
              end
            end
          end
        end else begin
          ticks_nxt = '0;
          phase_nxt = near ? PH_LED_ON : PH_TRIG_LOW;
        end
      end
      PH_LED_ON: begin
        if (ticks_inc >= blink_r) begin
          ticks_nxt = '0;
          phase_nxt = PH_LED_OFF;
        end else begin
          ticks_nxt = ticks_inc;
        end
      end
      PH_LED_OFF: begin
        if (ticks_inc >= blink_r) begin
          ticks_nxt = '0;
          phase_nxt = PH_TRIG_LOW;
        end else begin
          ticks_nxt = ticks_inc;
        end
      end
      default: begin
        ticks_nxt = '0;
        phase_nxt = PH_TRIG_LOW;
      end
    endcase
  end

  // Result of the current tick. The measurement fields are zero except on
  // the tick where the echo falls.
  always_comb begin
    res_nxt = '0;
    unique case (phase_r)
      PH_TRIG_HIGH: res_nxt.trigger_out = 1'b1;
      PH_LED_ON:    res_nxt.led_out     = 1'b1;
      PH_COUNT: begin
        if (!in_chan.echo_level) begin
          res_nxt.result_valid   = 1'b1;
          res_nxt.distance_cm    = dist_r;
          res_nxt.digit_hundreds = d100_r;
          res_nxt.digit_tens     = d10_r;
          res_nxt.digit_ones     = d1_r;
          res_nxt.near_flag      = near;
        end
      end
      default: ;
    endcase
  end

  // State advances once per accepted tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TRIG_LOW;
      ticks_r <= '0;
      count_r <= '0;
      rem_r   <= '0;
      dist_r  <= '0;
      d100_r  <= '0;
      d10_r   <= '0;
      d1_r    <= '0;
    end else if (push) begin
      phase_r <= phase_nxt;
      ticks_r <= ticks_nxt;
      count_r <= count_nxt;
      rem_r   <= rem_nxt;
      dist_r  <= dist_nxt;
      d100_r  <= d100_nxt;
      d10_r   <= d10_nxt;
      d1_r    <= d1_nxt;
    end
  end

  // Output buffering. While the skid register is full no beat is taken, so
  // a pop then only moves the skid result forward.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (pop) begin
        skid_v_r <= 1'b0;
      end
    end else if (push) begin
      if (main_free) begin
        main_v_r <= 1'b1;
      end else begin
        skid_v_r <= 1'b1;
      end
    end else if (pop) begin
      main_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (pop) begin
        main_r <= skid_r;
      end
    end else if (push) begin
      if (main_free) begin
        main_r <= res_nxt;
      end else begin
        skid_r <= res_nxt;
      end
    end
  end

  assign out_chan.valid          = main_v_r;
  assign out_chan.trigger_out    = main_r.trigger_out;
  assign out_chan.led_out        = main_r.led_out;
  assign out_chan.result_valid   = main_r.result_valid;
  assign out_chan.distance_cm    = main_r.distance_cm;
  assign out_chan.digit_hundreds = main_r.digit_hundreds;
  assign out_chan.digit_tens     = main_r.digit_tens;
  assign out_chan.digit_ones     = main_r.digit_ones;
  assign out_chan.near_flag      = main_r.near_flag;

endmodule

`default_nettype wire
